FILE: hdl/qnrf_pkg.sv
// ----------------------------------------------------------------------------
// qnrf_pkg
// Shared types, constants and saturation helpers for the quartic root finder.
// ----------------------------------------------------------------------------
package qnrf_pkg;

  localparam int MAX_ROOTS = 4;
  localparam int CNT_W     = $clog2(MAX_ROOTS + 1);
  localparam int IDX_W     = (MAX_ROOTS > 1) ? $clog2(MAX_ROOTS) : 1;

  localparam int NUM_W     = 56;
  localparam int QUO_W     = 57;
  localparam int DIV_CNT_W = 6;

  localparam logic [32:0] STEP_TOL = 33'd168;
  localparam logic [32:0] DUP_TOL  = 33'd16777;

  localparam logic [2:0] CFG_C4    = 3'd0;
  localparam logic [2:0] CFG_C3    = 3'd1;
  localparam logic [2:0] CFG_C2    = 3'd2;
  localparam logic [2:0] CFG_C1    = 3'd3;
  localparam logic [2:0] CFG_C0    = 3'd4;
  localparam logic [2:0] CFG_STEP  = 3'd5;
  localparam logic [2:0] CFG_MAXIT = 3'd6;

  localparam logic [27:0] STEP_RST  = 28'd1677722;
  localparam logic [7:0]  MAXIT_RST = 8'd64;

  typedef enum logic [2:0] {
    ST_NO_CHANGE = 3'd0,
    ST_NEW_ROOT  = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_ZERO_DERIV = 3'd3,
    ST_NO_CONV   = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL_L, S_EVAL_R, S_IT_F, S_IT_D, S_DIV, S_STEP, S_IT_F1, S_DUP, S_DONE
  } seq_state_t;

  typedef struct packed {
    logic signed [31:0] c4;
    logic signed [31:0] c3;
    logic signed [31:0] c2;
    logic signed [31:0] c1;
    logic signed [31:0] c0;
    logic signed [31:0] d4;
    logic signed [31:0] d3;
    logic signed [31:0] d2;
  } coef_set_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [32:0] abs_diff(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

endpackage

FILE: hdl/qnrf_if.sv
// ----------------------------------------------------------------------------
// qnrf_if
// Valid/ready channels for interval items and root results.
// ----------------------------------------------------------------------------
interface qnrf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] interval_start;
  logic               clear_store;
  modport source (output valid, output interval_start, output clear_store, input ready);
  modport sink   (input valid, input interval_start, input clear_store, output ready);
endinterface

interface qnrf_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] root_value;
  logic [7:0]         iteration_count;
  logic [2:0]         roots_held;
  modport source (output valid, output status, output root_value, output iteration_count,
                  output roots_held, input ready);
  modport sink   (input valid, input status, input root_value, input iteration_count,
                  input roots_held, output ready);
endinterface

FILE: hdl/qnrf_horner.sv
// ----------------------------------------------------------------------------
// qnrf_horner
// Shared Horner unit: one multiply, then round, add and saturate, per stage.
// ----------------------------------------------------------------------------
module qnrf_horner
  import qnrf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               deriv,
  input  logic signed [31:0] x,
  input  coef_set_t          coefs,
  output logic               done,
  output logic signed [31:0] result
);

  logic               busy_r, busy_nxt;
  logic               ph_r, ph_nxt;
  logic               done_r, done_nxt;
  logic               deriv_r;
  logic [1:0]         cnt_r;
  logic signed [31:0] acc_r;
  logic signed [31:0] x_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] coef_sel;
  logic signed [63:0] rounded;
  logic [1:0]         last;

  assign last = deriv_r ? 2'd2 : 2'd3;

  always_comb begin
    unique case (cnt_r)
      2'd0:    coef_sel = deriv_r ? coefs.d3 : coefs.c3;
      2'd1:    coef_sel = deriv_r ? coefs.d2 : coefs.c2;
      2'd2:    coef_sel = coefs.c1;
      default: coef_sel = coefs.c0;
    endcase
  end

  assign rounded = (prod_r + 64'sd8388608) >>> 24;

  always_comb begin
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      ph_nxt   = 1'b0;
    end else if (busy_r) begin
      ph_nxt = ~ph_r;
      if (ph_r && cnt_r == last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r   <= deriv ? coefs.d4 : coefs.c4;
      x_r     <= x;
      deriv_r <= deriv;
      cnt_r   <= 2'd0;
    end else if (busy_r) begin
      if (!ph_r) begin
        prod_r <= 64'(acc_r) * 64'(x_r);
      end else begin
        acc_r <= sat32(rounded + 64'(coef_sel));
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

FILE: hdl/qnrf_div.sv
// ----------------------------------------------------------------------------
// qnrf_div
// Serial restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module qnrf_div
  import qnrf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [31:0]      den,
  output logic                    done,
  output logic signed [QUO_W-1:0] quot
);

  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [31:0]          rem_r;
  logic [NUM_W-1:0]     qt_r;
  logic [31:0]          dmag_r;
  logic                 neg_r;
  logic [32:0]          shifted;
  logic                 fits;
  logic signed [QUO_W-1:0] qpos;

  assign shifted = {rem_r, qt_r[NUM_W-1]};
  assign fits    = shifted >= {1'b0, dmag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qt_r   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dmag_r <= den[31] ? 32'(-den) : 32'(den);
      neg_r  <= num[NUM_W-1] ^ den[31];
      rem_r  <= 32'd0;
      cnt_r  <= DIV_CNT_W'(NUM_W);
    end else if (busy_r) begin
      rem_r <= fits ? 32'(shifted - {1'b0, dmag_r}) : shifted[31:0];
      qt_r  <= {qt_r[NUM_W-2:0], fits};
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  assign qpos = $signed({1'b0, qt_r});
  assign quot = neg_r ? -qpos : qpos;
  assign done = done_r;

endmodule

FILE: hdl/quartic_newton_root_finder.sv
// ----------------------------------------------------------------------------
// quartic_newton_root_finder
// Scans one interval per beat for a sign change of a quartic polynomial and
// refines the root by Newton-Raphson in Q8.24 fixed point.
// ----------------------------------------------------------------------------
// Usage: write coefficients, step and iteration cap on the cfg_ port while
// idle. Each in_ch beat gives a left interval end and a store-clear flag; each
// accepted beat yields exactly one out_ch beat with status, root, iteration
// count and number of stored roots.
// Each item takes two evaluations of f, then, on a sign change, per Newton
// iteration f and f', a serial divide, a step check and possibly one more f.
// One shared multiplier and one serial divider do this work. One item is in
// work at a time; in_ch.ready is low until its result is registered. Reset
// clears the root count and restores the register defaults. A stalled
// receiver holds out_ch; the next item may be taken meanwhile but its result
// waits until the held beat is taken.
// ----------------------------------------------------------------------------
module quartic_newton_root_finder
  import qnrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  qnrf_in_if.sink     in_ch,
  qnrf_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  seq_state_t state_r, state_nxt;

  logic signed [31:0] c4_r, c3_r, c2_r, c1_r, c0_r;
  logic [27:0]        step_r;
  logic [7:0]         maxit_r;
  coef_set_t          coefs;

  logic signed [31:0] found_r [MAX_ROOTS];
  logic [CNT_W-1:0]   cnt_r;

  logic signed [31:0] left_r, right_r, x0_r, x1_r, fl_r, f_r, d_r;
  logic [7:0]         k_r;
  status_t            status_r;
  logic signed [31:0] root_r;
  logic [7:0]         iters_r;

  logic               out_valid_r;
  status_t            out_status_r;
  logic signed [31:0] out_root_r;
  logic [7:0]         out_iters_r;
  logic [2:0]         out_held_r;

  logic               hkick_r, dkick_r;
  logic               h_done, d_done;
  logic signed [31:0] h_res, h_x;
  logic signed [QUO_W-1:0] quot;
  logic               sign_flip, step_small, fresh, out_free, accept;

  assign coefs = '{c4: c4_r, c3: c3_r, c2: c2_r, c1: c1_r, c0: c0_r,
                   d4: sat32(64'(c4_r) * 64'sd4),
                   d3: sat32(64'(c3_r) * 64'sd3),
                   d2: sat32(64'(c2_r) * 64'sd2)};

  always_comb begin
    unique case (state_r)
      S_EVAL_L: h_x = left_r;
      S_EVAL_R: h_x = right_r;
      S_IT_F1:  h_x = x1_r;
      default:  h_x = x0_r;
    endcase
  end

  qnrf_horner u_horner (
    .clk, .rst_n, .start(hkick_r), .deriv(state_r == S_IT_D), .x(h_x),
    .coefs, .done(h_done), .result(h_res)
  );

  qnrf_div u_div (
    .clk, .rst_n, .start(dkick_r), .num({f_r, 24'd0}), .den(d_r),
    .done(d_done), .quot
  );

  assign sign_flip  = (fl_r[31] && !h_res[31] && h_res != 32'sd0) ||
                      (!fl_r[31] && fl_r != 32'sd0 && h_res[31]);
  assign step_small = abs_diff(x1_r, x0_r) <= STEP_TOL;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign accept     = in_ch.valid && in_ch.ready;

  always_comb begin
    fresh = 1'b1;
    for (int i = 0; i < MAX_ROOTS; i++) begin
      if (CNT_W'(i) < cnt_r && abs_diff(found_r[i], x1_r) <= DUP_TOL) begin
        fresh = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_EVAL_L;
      S_EVAL_L: if (h_done) state_nxt = S_EVAL_R;
      S_EVAL_R: begin
        if (h_done) begin
          state_nxt = (!sign_flip || maxit_r == 8'd0) ? S_DONE : S_IT_F;
        end
      end
      S_IT_F:   if (h_done) state_nxt = S_IT_D;
      S_IT_D:   if (h_done) state_nxt = (h_res == 32'sd0) ? S_DONE : S_DIV;
      S_DIV:    if (d_done) state_nxt = S_STEP;
      S_STEP:   state_nxt = step_small ? S_DUP : S_IT_F1;
      S_IT_F1: begin
        if (h_done) begin
          priority if (h_res == 32'sd0) state_nxt = S_DUP;
          else if (k_r == maxit_r)      state_nxt = S_DONE;
          else                          state_nxt = S_IT_F;
        end
      end
      S_DUP:    state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hkick_r <= 1'b0;
      dkick_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hkick_r <= (state_nxt != state_r) &&
                 (state_nxt == S_EVAL_L || state_nxt == S_EVAL_R ||
                  state_nxt == S_IT_F || state_nxt == S_IT_D || state_nxt == S_IT_F1);
      dkick_r <= (state_nxt == S_DIV) && (state_r != S_DIV);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_r    <= '0;
      c3_r    <= '0;
      c2_r    <= '0;
      c1_r    <= '0;
      c0_r    <= '0;
      step_r  <= STEP_RST;
      maxit_r <= MAXIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_C4:    c4_r    <= cfg_wdata;
        CFG_C3:    c3_r    <= cfg_wdata;
        CFG_C2:    c2_r    <= cfg_wdata;
        CFG_C1:    c1_r    <= cfg_wdata;
        CFG_C0:    c0_r    <= cfg_wdata;
        CFG_STEP:  step_r  <= cfg_wdata[27:0];
        CFG_MAXIT: maxit_r <= cfg_wdata[7:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept && in_ch.clear_store) begin
      cnt_r <= '0;
    end else if (state_r == S_DUP && fresh && cnt_r < CNT_W'(MAX_ROOTS)) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DUP && fresh && cnt_r < CNT_W'(MAX_ROOTS)) begin
      found_r[cnt_r[IDX_W-1:0]] <= x1_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        left_r   <= in_ch.interval_start;
        right_r  <= sat32(64'(in_ch.interval_start) + 64'(step_r));
        status_r <= ST_NO_CHANGE;
        root_r   <= '0;
        iters_r  <= '0;
      end
      S_EVAL_L: if (h_done) fl_r <= h_res;
      S_EVAL_R: begin
        if (h_done) begin
          x0_r <= left_r;
          k_r  <= 8'd1;
          if (sign_flip && maxit_r == 8'd0) status_r <= ST_NO_CONV;
        end
      end
      S_IT_F: if (h_done) f_r <= h_res;
      S_IT_D: begin
        if (h_done) begin
          d_r <= h_res;
          if (h_res == 32'sd0) begin
            status_r <= ST_ZERO_DERIV;
            iters_r  <= k_r;
          end
        end
      end
      S_DIV: if (d_done) x1_r <= sat32(64'(x0_r) - 64'(quot));
      S_IT_F1: begin
        if (h_done && h_res != 32'sd0) begin
          if (k_r == maxit_r) begin
            status_r <= ST_NO_CONV;
            iters_r  <= k_r;
          end else begin
            x0_r <= x1_r;
            k_r  <= k_r + 8'd1;
          end
        end
      end
      S_DUP: begin
        root_r  <= x1_r;
        iters_r <= k_r;
        priority if (!fresh)                   status_r <= ST_DUPLICATE;
        else if (cnt_r < CNT_W'(MAX_ROOTS))    status_r <= ST_NEW_ROOT;
        else                                   status_r <= ST_FULL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_status_r <= status_r;
      out_root_r   <= root_r;
      out_iters_r  <= iters_r;
      out_held_r   <= 3'(cnt_r);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.root_value      = out_root_r;
  assign out_ch.iteration_count = out_iters_r;
  assign out_ch.roots_held      = out_held_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ROOTS)) else $error("root count above store depth");

  a_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_NO_CHANGE || out_status_r == ST_ZERO_DERIV ||
                    out_status_r == ST_NO_CONV) |-> out_root_r == 32'sd0)
    else $error("root value set without convergence");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EVAL_L && hkick_r) else $error("accepted beat not evaluated");
`endif

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quartic Newton root finder: a queue-fed driver
// offers interval beats, an in-bench model predicts status, root, iteration
// count and store occupancy, and a monitor checks each result beat in order.
// ----------------------------------------------------------------------------
module tb;
  import qnrf_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam longint ONE = 64'sd16777216;
  localparam longint QONE = 64'sd65536;

  typedef struct {
    logic signed [31:0] start;
    logic               clr;
  } interval_t;

  typedef struct {
    logic [2:0]         status;
    logic signed [31:0] root;
    logic [7:0]         iters;
    logic [2:0]         held;
  } root_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_C4;
  logic [31:0] cfg_wdata = '0;

  qnrf_in_if in_ch();
  qnrf_out_if out_ch();

  quartic_newton_root_finder uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  interval_t    pending_q[$];
  root_result_t expected_q[$];
  int errors = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int idle_cycles = 0;

  longint c4, c3, c2, c1, c0, step_w, maxit;
  longint roots[MAX_ROOTS];
  int     root_cnt;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint stage(longint acc, longint x, longint c);
    return clamp32(((acc * x + 64'sd8388608) >>> 24) + c);
  endfunction

  function automatic longint poly_f(longint x);
    longint a;
    a = stage(c4, x, c3);
    a = stage(a, x, c2);
    a = stage(a, x, c1);
    return stage(a, x, c0);
  endfunction

  function automatic longint poly_df(longint x);
    longint a;
    a = stage(clamp32(4 * c4), x, clamp32(3 * c3));
    a = stage(a, x, clamp32(2 * c2));
    return stage(a, x, c1);
  endfunction

  function automatic int sgn(longint v);
    return (v > 0) - (v < 0);
  endfunction

  function automatic root_result_t predict_root(interval_t it);
    root_result_t r;
    longint left, right, x0, x1, fv, dv, q, diff, rt, d;
    bit conv, fresh;
    status_t st;
    int n;
    conv = 0;
    rt = 0;
    n = 0;
    st = ST_NO_CONV;
    if (it.clr) root_cnt = 0;
    left = longint'(it.start);
    right = clamp32(left + step_w);
    if (sgn(poly_f(left)) * sgn(poly_f(right)) >= 0) begin
      st = ST_NO_CHANGE;
    end else begin
      x0 = left;
      for (int k = 1; k <= maxit; k++) begin
        fv = poly_f(x0);
        dv = poly_df(x0);
        n = k;
        if (dv == 0) begin
          st = ST_ZERO_DERIV;
          break;
        end
        q = (fv * ONE) / dv;
        x1 = clamp32(x0 - q);
        diff = x1 - x0;
        if (diff < 0) diff = -diff;
        if (diff <= 168 || poly_f(x1) == 0) begin
          conv = 1;
          rt = x1;
          break;
        end
        x0 = x1;
      end
      if (conv) begin
        fresh = 1;
        for (int i = 0; i < root_cnt; i++) begin
          d = roots[i] - rt;
          if (d < 0) d = -d;
          if (d <= 16777) fresh = 0;
        end
        if (!fresh) begin
          st = ST_DUPLICATE;
        end else if (root_cnt < MAX_ROOTS) begin
          roots[root_cnt] = rt;
          root_cnt++;
          st = ST_NEW_ROOT;
        end else begin
          st = ST_FULL;
        end
      end
    end
    r.status = st;
    r.root = conv ? rt[31:0] : 32'd0;
    r.iters = n[7:0];
    r.held = root_cnt[2:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        interval_t acc;
        acc.start = in_ch.interval_start;
        acc.clr = in_ch.clear_store;
        expected_q.push_back(predict_root(acc));
        gap_left = pick_gap();
      end
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        interval_t nx;
        nx = pending_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.interval_start <= nx.start;
        in_ch.clear_store <= nx.clr;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver ready and long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
      out_ch.ready <= 1'b0;
    end else begin
      int p;
      p = $urandom_range(0, 99);
      if (p < 65) out_ch.ready <= 1'b1;
      else if (p < 95) out_ch.ready <= 1'b0;
      else begin
        out_ch.ready <= 1'b0;
        hold_left <= $urandom_range(20, 150);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: status %0d root %h",
                                   out_ch.status, out_ch.root_value);
      end else begin
        root_result_t e;
        e = expected_q.pop_front();
        if (out_ch.status !== e.status || out_ch.root_value !== e.root ||
            out_ch.iteration_count !== e.iters || out_ch.roots_held !== e.held) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st %0d root %h it %0d held %0d, got st %0d root %h it %0d held %0d",
                     e.status, e.root, e.iters, e.held, out_ch.status, out_ch.root_value,
                     out_ch.iteration_count, out_ch.roots_held);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_C4:    c4 = longint'($signed(val));
      CFG_C3:    c3 = longint'($signed(val));
      CFG_C2:    c2 = longint'($signed(val));
      CFG_C1:    c1 = longint'($signed(val));
      CFG_C0:    c0 = longint'($signed(val));
      CFG_STEP:  step_w = longint'(val[27:0]);
      CFG_MAXIT: maxit = longint'(val[7:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_poly(longint a4, longint a3, longint a2, longint a1, longint a0);
    write_reg(CFG_C4, a4[31:0]);
    write_reg(CFG_C3, a3[31:0]);
    write_reg(CFG_C2, a2[31:0]);
    write_reg(CFG_C1, a1[31:0]);
    write_reg(CFG_C0, a0[31:0]);
  endtask

  task automatic push_item(longint s, bit clr);
    interval_t it;
    it.start = s[31:0];
    it.clr = clr;
    pending_q.push_back(it);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || expected_q.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic longint rnd_s(int mag);
    return longint'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  initial begin
    c4 = 0; c3 = 0; c2 = 0; c1 = 0; c0 = 0;
    step_w = longint'(STEP_RST);
    maxit = longint'(MAXIT_RST);
    root_cnt = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // all-zero polynomial after reset
    push_item(0, 1);
    push_item(64'sd2147483647, 0);
    push_item(-64'sd2147483648, 1);
    drain();

    // four roots at +-1 and +-2, then a duplicate
    set_poly(QONE, 0, -5 * QONE, 0, 4 * QONE);
    push_item(-2 * ONE - ONE / 20, 1);
    push_item(-ONE - ONE / 20, 0);
    push_item(ONE - ONE / 20, 0);
    push_item(2 * ONE - ONE / 20, 0);
    push_item(ONE - ONE / 30, 0);
    drain();

    // store full, exact zero at an end, then clear
    set_poly(0, 0, QONE, 0, -9 * QONE);
    push_item(3 * ONE - ONE / 20, 0);
    push_item(3 * ONE, 0);
    push_item(3 * ONE - ONE / 20, 1);
    drain();

    // zero derivative at the left end
    set_poly(0, QONE, 0, 0, -10);
    push_item(0, 0);
    drain();

    // iteration cap extremes and step extremes
    set_poly(0, 0, QONE, 0, -2 * QONE);
    write_reg(CFG_STEP, 32'd8388608);
    write_reg(CFG_MAXIT, 32'd1);
    push_item(ONE, 0);
    drain();
    write_reg(CFG_MAXIT, 32'd0);
    push_item(ONE, 0);
    drain();
    write_reg(CFG_MAXIT, 32'd255);
    write_reg(CFG_STEP, 32'd0);
    push_item(ONE, 0);
    drain();
    write_reg(CFG_STEP, 32'd167772160);
    push_item(-5 * ONE, 0);
    push_item(0, 0);
    push_item(64'sd2147483647, 0);
    drain();

    // saturating coefficients
    write_reg(CFG_STEP, 32'd1);
    write_reg(CFG_MAXIT, 32'd64);
    set_poly(64'sd2147483647, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
             64'sd2147483647);
    push_item($urandom, 0);
    push_item($urandom, 1);
    push_item(0, 0);
    drain();
    write_reg(CFG_STEP, 32'hffffffff);
    set_poly(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647,
             -64'sd2147483648);
    push_item($urandom, 0);
    push_item(-ONE, 0);
    drain();

    // random phases
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 8) begin
        set_poly($urandom, $urandom, $urandom, $urandom, $urandom);
        write_reg(CFG_STEP, $urandom);
      end else begin
        set_poly(QONE * ($urandom_range(0, 2) - 1), rnd_s(2 * 65536), rnd_s(8 * 65536),
                 rnd_s(8 * 65536), rnd_s(8 * 65536));
        write_reg(CFG_STEP, $urandom_range(1, 1 << 25));
      end
      write_reg(CFG_MAXIT, $urandom_range(1, 80));
      if (ph == 2) hold_req = 1;
      for (int i = 0; i < 22; i++) begin
        if ($urandom_range(0, 99) < 80) push_item(rnd_s(1 << 26), $urandom_range(0, 9) == 0);
        else push_item($urandom, $urandom_range(0, 9) == 0);
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: quartic_newton_root_finder.f
hdl/qnrf_pkg.sv
hdl/qnrf_if.sv
hdl/qnrf_horner.sv
hdl/qnrf_div.sv
hdl/quartic_newton_root_finder.sv
test/tb.sv
